### hdl/assert_macros.svh
// Assertion macros used by the RTL of the meter reading scaler.
// Each macro expands to a clocked concurrent assertion, or to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define MRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define MRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define MRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/mrs_pkg.sv
// Package for the meter reading scaler: widths, selector and register codes,
// default divisors and the item record that moves down the divider chain. No dependencies.
`timescale 1ns / 1ps

package mrs_pkg;

	localparam int RAW_W  = 24;
	localparam int DIV_W  = 16;
	localparam int ACC_W  = 28;
	localparam int OUT_W  = 29;
	localparam int CELLS  = ACC_W;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [DIV_W-1:0] PWR_DEFAULT_DIV  = 16'd186;
	localparam logic [DIV_W-1:0] VOLT_DEFAULT_DIV = 16'd1200;
	localparam logic [DIV_W-1:0] CURR_DEFAULT_DIV = 16'd100;
	localparam logic [ACC_W-1:0] CURR_FLOOR       = 28'd50;

	typedef enum logic [1:0] {
		FUNC_POWER  = 2'd0,
		FUNC_VOLT   = 2'd1,
		FUNC_CURR   = 2'd2,
		FUNC_UNUSED = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_POWER   = 2'd0,
		REG_VOLT    = 2'd1,
		REG_CURR    = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	// One item in flight: the dividend shifts out of acc from the top while
	// quotient bits shift in at the bottom.
	typedef struct packed {
		func_t              func;
		logic               neg;
		logic               flr_en;
		logic               zero;
		logic [DIV_W-1:0]   div;
		logic [DIV_W-1:0]   rem;
		logic [ACC_W-1:0]   acc;
	} mrs_item_t;

endpackage

### hdl/meter_reading_scaler.sv
// Meter reading scaler: one input stage, 28 division cells at one quotient bit each, one
// output register. Throughput one beat per cycle unless result_ready stalls the chain;
// every cell stage holds its item while stalled downstream.
// Reset clears all stage valid bits and the three coefficient registers to zero.
// Depends on mrs_pkg, mrs_prep, mrs_cell, mrs_post and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module meter_reading_scaler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mrs_pkg::ADDR_W-1:0]        paddr,
	input  logic [mrs_pkg::DATA_W-1:0]        pwdata,
	output logic [mrs_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [1:0]                        func,
	input  logic [mrs_pkg::RAW_W-1:0]         raw_reading,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [1:0]                        quantity,
	output logic signed [mrs_pkg::OUT_W-1:0]  scaled_value
);
	import mrs_pkg::*;

	logic [DIV_W-1:0] power_coeff_q;
	logic [DIV_W-1:0] voltage_coeff_q;
	logic [DIV_W-1:0] current_coeff_q;
	reg_idx_t         reg_idx;
	logic             wr_en;

	logic              chain_valid [CELLS+1];
	logic              chain_ready [CELLS+1];
	mrs_item_t         chain_item  [CELLS+1];

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_coeff_q   <= '0;
			voltage_coeff_q <= '0;
			current_coeff_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_POWER: power_coeff_q   <= pwdata[DIV_W-1:0];
				REG_VOLT:  voltage_coeff_q <= pwdata[DIV_W-1:0];
				REG_CURR:  current_coeff_q <= pwdata[DIV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_POWER: prdata = {{(DATA_W-DIV_W){1'b0}}, power_coeff_q};
			REG_VOLT:  prdata = {{(DATA_W-DIV_W){1'b0}}, voltage_coeff_q};
			REG_CURR:  prdata = {{(DATA_W-DIV_W){1'b0}}, current_coeff_q};
			default:   prdata = '0;
		endcase
	end

	mrs_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (item_valid),
		.in_ready      (item_ready),
		.func          (func),
		.raw_reading   (raw_reading),
		.power_coeff   (power_coeff_q),
		.voltage_coeff (voltage_coeff_q),
		.current_coeff (current_coeff_q),
		.out_valid     (chain_valid[0]),
		.out_ready     (chain_ready[0]),
		.out_item      (chain_item[0])
	);

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		mrs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ready  (chain_ready[k]),
			.in_item   (chain_item[k]),
			.out_valid (chain_valid[k+1]),
			.out_ready (chain_ready[k+1]),
			.out_item  (chain_item[k+1])
		);
	end

	mrs_post u_post (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (chain_valid[CELLS]),
		.in_ready     (chain_ready[CELLS]),
		.in_item      (chain_item[CELLS]),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.quantity     (quantity),
		.scaled_value (scaled_value)
	);

	// The input only stalls when every stage down to the output register is full.
	`MRS_ASSERT_IMP(a_stall_needs_full_out, clk, arst_n, !item_ready, result_valid)
	// An accepted beat always lands in the input stage.
	`MRS_ASSERT_NXT(a_beat_enters_prep, clk, arst_n, item_valid && item_ready, chain_valid[0])
	// The unused selector always yields zero.
	`MRS_ASSERT_IMP(a_unused_zero, clk, arst_n, result_valid && quantity == FUNC_UNUSED, scaled_value == '0)
	// RMS readings are never negative.
	`MRS_ASSERT_IMP(a_rms_nonneg, clk, arst_n, result_valid && (quantity == FUNC_VOLT || quantity == FUNC_CURR), !scaled_value[OUT_W-1])

endmodule

### hdl/mrs_prep.sv
// Input stage of the meter reading scaler: picks dividend magnitude, divisor and sign.
// Depends on mrs_pkg.
`timescale 1ns / 1ps

module mrs_prep (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic [mrs_pkg::RAW_W-1:0]    raw_reading,
	input  logic [mrs_pkg::DIV_W-1:0]    power_coeff,
	input  logic [mrs_pkg::DIV_W-1:0]    voltage_coeff,
	input  logic [mrs_pkg::DIV_W-1:0]    current_coeff,
	output logic                         out_valid,
	input  logic                         out_ready,
	output mrs_pkg::mrs_item_t           out_item
);
	import mrs_pkg::*;

	logic              valid_s1;
	mrs_item_t         item_s1;
	mrs_item_t         item_d;
	func_t             fsel;
	logic [RAW_W-1:0]  mag;
	logic [ACC_W-1:0]  mag_x;
	logic [ACC_W-1:0]  mag_x10;
	logic              en;

	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	always_comb begin
		fsel    = func_t'(func);
		mag     = (fsel == FUNC_POWER && raw_reading[RAW_W-1]) ? (~raw_reading + RAW_W'(1))
			: raw_reading;
		mag_x   = {{(ACC_W-RAW_W){1'b0}}, mag};
		mag_x10 = (mag_x << 3) + (mag_x << 1);

		item_d        = '0;
		item_d.func   = fsel;
		item_d.div    = {{(DIV_W-1){1'b0}}, 1'b1};
		item_d.acc    = mag_x;
		case (fsel)
			FUNC_POWER: begin
				item_d.neg = raw_reading[RAW_W-1];
				if (power_coeff != '0) begin
					item_d.acc = mag_x10;
					item_d.div = power_coeff;
				end else begin
					item_d.div = PWR_DEFAULT_DIV;
				end
			end
			FUNC_VOLT: begin
				item_d.div = (voltage_coeff != '0) ? voltage_coeff : VOLT_DEFAULT_DIV;
			end
			FUNC_CURR: begin
				if (current_coeff != '0) begin
					item_d.acc    = mag_x10;
					item_d.div    = current_coeff;
					item_d.flr_en = 1'b1;
				end else begin
					item_d.div = CURR_DEFAULT_DIV;
				end
			end
			default: begin
				item_d.zero = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			item_s1 <= item_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

### hdl/mrs_cell.sv
// One restoring division step: one quotient bit per cell, with its own stage register.
// Depends on mrs_pkg.
`timescale 1ns / 1ps

module mrs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrs_pkg::mrs_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mrs_pkg::mrs_item_t  out_item
);
	import mrs_pkg::*;

	logic              valid_q;
	mrs_item_t         item_q;
	mrs_item_t         item_d;
	logic [DIV_W:0]    shifted;
	logic [DIV_W:0]    trial;
	logic              qbit;
	logic              en;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	always_comb begin
		shifted = {in_item.rem, in_item.acc[ACC_W-1]};
		trial   = shifted - {1'b0, in_item.div};
		// The partial remainder stays below the divisor, so the top bit is the borrow.
		qbit    = !trial[DIV_W];
		item_d     = in_item;
		item_d.rem = qbit ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
		item_d.acc = {in_item.acc[ACC_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			item_q <= item_d;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

### hdl/mrs_post.sv
// Output stage of the meter reading scaler: applies sign, current floor and unused selector.
// Depends on mrs_pkg.
`timescale 1ns / 1ps

module mrs_post (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  mrs_pkg::mrs_item_t          in_item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [1:0]                  quantity,
	output logic signed [mrs_pkg::OUT_W-1:0] scaled_value
);
	import mrs_pkg::*;

	logic                 valid_q;
	logic [1:0]           quantity_q;
	logic [OUT_W-1:0]     value_q;
	logic [OUT_W-1:0]     value_d;
	logic [OUT_W-1:0]     mag;
	logic                 en;

	assign en       = !valid_q || result_ready;
	assign in_ready = en;

	always_comb begin
		mag = {{(OUT_W-ACC_W){1'b0}}, in_item.acc};
		if (in_item.zero || (in_item.flr_en && in_item.acc < CURR_FLOOR)) begin
			value_d = '0;
		end else if (in_item.neg) begin
			value_d = ~mag + OUT_W'(1);
		end else begin
			value_d = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			quantity_q <= in_item.func;
			value_q    <= value_d;
		end
	end

	assign result_valid = valid_q;
	assign quantity     = quantity_q;
	assign scaled_value = signed'(value_q);

endmodule
